/* hw/rtl/multi_channel_alarm_timer_core_assert.svh */
// assertion macros for the alarm timer core
`ifndef MULTI_CHANNEL_ALARM_TIMER_CORE_ASSERT_SVH
`define MULTI_CHANNEL_ALARM_TIMER_CORE_ASSERT_SVH

// condition that must hold on every clock edge out of reset
`define MCAT_CHECK(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("mcat check failed");

// antecedent implies consequent in the same cycle
`define MCAT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mcat implication failed");

`endif

/* hw/rtl/mcat_pkg.sv */
// shared types and constants of the alarm timer core
`timescale 1ns / 1ps
package mcat_pkg;

  localparam int TIMER_COUNT = 8;
  localparam int IDX_W       = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
  localparam int CNT_W       = $clog2(TIMER_COUNT + 1);
  localparam int MAX_FIRES   = 64;
  localparam int FIRE_CNT_W  = $clog2(MAX_FIRES + 1);
  localparam int TIME_W      = 64;
  localparam int FREQ_W      = 32;
  localparam int TICKS_W     = 32;
  localparam int PERIOD_W    = 52;
  localparam int DIVD_W      = 52;
  localparam int DIV_CNT_W   = $clog2(DIVD_W + 1);
  localparam int HANDLE_W    = 8;
  localparam int OUT_IDX_W   = 5;

  localparam logic [FREQ_W-1:0]   DEFAULT_FREQ = 32'd1000;
  localparam logic [19:0]         US_PER_S     = 20'd1000000;
  localparam logic [PERIOD_W-1:0] PERIOD_MAX   = '1;

  // input word layout
  localparam int IN_TDATA_W = 80;
  localparam int IN_H_LO    = 0;
  localparam int IN_F_LO    = 8;
  localparam int IN_T_LO    = 40;
  localparam int IN_RL_BIT  = 72;
  localparam int IN_EN_BIT  = 73;

  // output word layout
  localparam int OUT_TDATA_W = 72;
  localparam int OUT_OK_BIT  = 5;
  localparam int OUT_T_LO    = 6;

  localparam logic RES_ALLOC = 1'b0;
  localparam logic RES_FIRE  = 1'b1;

  typedef enum logic [2:0] {
    KIND_ALLOC  = 3'd0,
    KIND_SET_EN = 3'd1,
    KIND_ARM    = 3'd2,
    KIND_REMOVE = 3'd3,
    KIND_CLEAR  = 3'd4,
    KIND_TICK   = 3'd5
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ARM_MUL,
    ST_ARM_START,
    ST_ARM_WAIT,
    ST_ARM_WR,
    ST_SCAN,
    ST_DECIDE,
    ST_FIRE,
    ST_EMIT
  } state_t;

  // one timer entry in the table memory
  typedef struct packed {
    logic [TIME_W-1:0]   due_time;
    logic [PERIOD_W-1:0] period;
    logic [FREQ_W-1:0]   frequency;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [FREQ_W-1:0] divisor;
  } div_req_t;

endpackage

/* hw/rtl/mcat_ram.sv */
// generic single write port ram with registered read
`timescale 1ns / 1ps
module mcat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                              clk,
  input  logic                              we,
  input  logic [((DEPTH>1)?$clog2(DEPTH):1)-1:0] waddr,
  input  logic [WIDTH-1:0]                  wdata,
  input  logic                              re,
  input  logic [((DEPTH>1)?$clog2(DEPTH):1)-1:0] raddr,
  output logic [WIDTH-1:0]                  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/mcat_div.sv */
// bit-serial restoring divider for the alarm period
`timescale 1ns / 1ps
module mcat_div
  import mcat_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  div_req_t          req,
  output logic              done,
  output logic [DIVD_W-1:0] quotient
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [FREQ_W-1:0]    rem;
  logic [FREQ_W-1:0]    dvs;
  logic [FREQ_W:0]      trial;
  logic [FREQ_W:0]      diff;
  logic                 ge;

  // one quotient bit per cycle
  assign trial = {rem, quotient[DIVD_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign ge    = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIVD_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem      <= '0;
      dvs      <= req.divisor;
      quotient <= req.dividend;
    end else if (busy) begin
      rem      <= ge ? diff[FREQ_W-1:0] : trial[FREQ_W-1:0];
      quotient <= {quotient[DIVD_W-2:0], ge};
    end
  end

endmodule

/* hw/rtl/multi_channel_alarm_timer_core.sv */
// Bank of TIMER_COUNT alarm timers on a microsecond time base. Commands come in as
// one word each on the s_axis side (kind in tuser); allocation answers and timer fires
// leave as words on the m_axis side, tlast on the final word of a command. Frequency,
// period and due time of each timer sit in one table memory with registered read; the
// flags sit in flip-flops. Arm computes the period with the 52-step serial divider
// unless the frequency read is zero. A tick scans the table once per fire and once
// more, at most 64 fires per tick. Allocate and tick wait while the output word is
// still held.
// No clearing pass is needed after reset.
`timescale 1ns / 1ps
module multi_channel_alarm_timer_core
  import mcat_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // timer_handle, frequency, alarm_ticks, reload, enable, zero pad
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // kind
  input  logic [2:0]             s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // timer_index, alloc_ok, fire_time, zero pad
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // result_kind
  output logic                   m_axis_tuser,
  output logic                   m_axis_tlast
);

  state_t state, state_next;

  logic [TIMER_COUNT-1:0] active, enabled, auto_rl, armed, entry_valid;
  logic [TIMER_COUNT-1:0] cand;

  logic [TIME_W-1:0]     current_time, target;
  logic [HANDLE_W-1:0]   h_in;
  logic                  h_ok;
  logic [IDX_W-1:0]      idx_in, h_q;
  logic [TICKS_W-1:0]    ticks_q;
  logic                  reload_q;
  logic [DIVD_W-1:0]     prod_q;
  logic [FREQ_W-1:0]     freq_q, freq_in;
  logic [PERIOD_W-1:0]   p_q, p_eff;

  logic                  free_found;
  logic [IDX_W-1:0]      free_idx;

  logic                  ram_we, ram_re, rd_valid_q;
  logic [IDX_W-1:0]      ram_waddr, ram_raddr;
  entry_t                ram_wdata, rdata;

  div_req_t              div_req;
  logic                  div_done;
  logic [DIVD_W-1:0]     div_q;

  logic [CNT_W-1:0]      cnt;
  logic [IDX_W-1:0]      eval_idx, pick;
  logic                  found;
  logic [TIME_W-1:0]     best;
  entry_t                pick_entry;
  logic [FIRE_CNT_W-1:0] fires;

  logic                  pend_v, pend_kind, pend_ok;
  logic [IDX_W-1:0]      pend_idx;
  logic [TIME_W-1:0]     pend_time;

  logic                  out_free, push, push_last, go;

  // field extraction
  assign h_in     = s_axis_tdata[IN_H_LO +: HANDLE_W];
  assign h_ok     = h_in < HANDLE_W'(TIMER_COUNT);
  assign idx_in   = IDX_W'(h_in);
  assign freq_in  = (s_axis_tdata[IN_F_LO +: FREQ_W] == '0) ? DEFAULT_FREQ
                                                            : s_axis_tdata[IN_F_LO +: FREQ_W];
  assign cand     = active & enabled & armed;
  assign eval_idx = IDX_W'(cnt - 1'b1);
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign go       = !pend_v || out_free;
  assign p_eff    = (p_q == '0) ? PERIOD_W'(1) : p_q;

  // lowest free timer
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = TIMER_COUNT - 1; i >= 0; i--) begin
      if (!active[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  mcat_ram #(.WIDTH(ENTRY_W), .DEPTH(TIMER_COUNT)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  mcat_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_q)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and control
  always_comb begin
    state_next       = state;
    s_axis_tready    = 1'b0;
    ram_we           = 1'b0;
    ram_waddr        = '0;
    ram_wdata        = '0;
    ram_re           = 1'b0;
    ram_raddr        = '0;
    div_req.start    = 1'b0;
    div_req.dividend = prod_q;
    div_req.divisor  = freq_q;
    push             = 1'b0;
    push_last        = 1'b0;
    case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          case (kind_t'(s_axis_tuser))
            KIND_ALLOC: begin
              if (free_found) begin
                ram_we              = 1'b1;
                ram_waddr           = free_idx;
                ram_wdata.frequency = freq_in;
              end
              state_next = ST_EMIT;
            end
            KIND_ARM: begin
              if (h_ok) begin
                ram_re     = 1'b1;
                ram_raddr  = idx_in;
                state_next = ST_ARM_MUL;
              end
            end
            KIND_TICK: state_next = ST_SCAN;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_ARM_MUL: state_next = ST_ARM_START;
      ST_ARM_START: begin
        if (freq_q != '0) begin
          div_req.start = 1'b1;
          state_next    = ST_ARM_WAIT;
        end else begin
          state_next = ST_ARM_WR;
        end
      end
      ST_ARM_WAIT: begin
        if (div_done) begin
          state_next = ST_ARM_WR;
        end
      end
      ST_ARM_WR: begin
        ram_we              = 1'b1;
        ram_waddr           = h_q;
        ram_wdata.frequency = freq_q;
        ram_wdata.period    = p_eff;
        ram_wdata.due_time  = current_time + TIME_W'(p_eff);
        state_next          = ST_IDLE;
      end
      ST_SCAN: begin
        if (cnt < CNT_W'(TIMER_COUNT)) begin
          ram_re    = 1'b1;
          ram_raddr = IDX_W'(cnt);
        end else begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (found && fires < FIRE_CNT_W'(MAX_FIRES)) begin
          state_next = ST_FIRE;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_FIRE: begin
        if (go) begin
          push = pend_v;
          if (auto_rl[pick]) begin
            ram_we             = 1'b1;
            ram_waddr          = pick;
            ram_wdata          = pick_entry;
            ram_wdata.due_time = best + TIME_W'(pick_entry.period);
          end
          state_next = ST_SCAN;
        end
      end
      ST_EMIT: begin
        if (go) begin
          push       = pend_v;
          push_last  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // timer flags
  always_ff @(posedge clk) begin
    if (rst) begin
      active      <= '0;
      enabled     <= '0;
      auto_rl     <= '0;
      armed       <= '0;
      entry_valid <= '0;
    end else begin
      if (state == ST_IDLE && s_axis_tvalid) begin
        case (kind_t'(s_axis_tuser))
          KIND_ALLOC: begin
            if (free_found) begin
              active[free_idx]      <= 1'b1;
              enabled[free_idx]     <= 1'b0;
              auto_rl[free_idx]     <= 1'b0;
              armed[free_idx]       <= 1'b0;
              entry_valid[free_idx] <= 1'b1;
            end
          end
          KIND_SET_EN: begin
            if (h_ok) begin
              enabled[idx_in] <= s_axis_tdata[IN_EN_BIT];
            end
          end
          KIND_REMOVE: begin
            if (h_ok) begin
              active[idx_in]      <= 1'b0;
              enabled[idx_in]     <= 1'b0;
              auto_rl[idx_in]     <= 1'b0;
              armed[idx_in]       <= 1'b0;
              entry_valid[idx_in] <= 1'b0;
            end
          end
          KIND_CLEAR: begin
            active      <= '0;
            enabled     <= '0;
            auto_rl     <= '0;
            armed       <= '0;
            entry_valid <= '0;
          end
          default: ;
        endcase
      end
      if (state == ST_ARM_WR) begin
        armed[h_q]       <= 1'b1;
        auto_rl[h_q]     <= reload_q;
        entry_valid[h_q] <= 1'b1;
      end
      if (state == ST_FIRE && go && !auto_rl[pick]) begin
        armed[pick] <= 1'b0;
      end
    end
  end

  // time base, scan state and pending answer
  always_ff @(posedge clk) begin
    if (rst) begin
      current_time <= '0;
      pend_v       <= 1'b0;
      fires        <= '0;
      cnt          <= '0;
      found        <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid && kind_t'(s_axis_tuser) == KIND_ALLOC) begin
            pend_v    <= 1'b1;
            pend_kind <= RES_ALLOC;
            pend_idx  <= free_found ? free_idx : '0;
            pend_ok   <= free_found;
            pend_time <= '0;
          end
          target <= current_time + 1'b1;
          best   <= current_time + 1'b1;
          cnt    <= '0;
          found  <= 1'b0;
          fires  <= '0;
        end
        ST_SCAN: begin
          cnt <= cnt + 1'b1;
          if (cnt != '0 && cand[eval_idx] && rdata.due_time <= best) begin
            found      <= 1'b1;
            pick       <= eval_idx;
            best       <= rdata.due_time;
            pick_entry <= rdata;
          end
        end
        ST_DECIDE: begin
          if (!(found && fires < FIRE_CNT_W'(MAX_FIRES))) begin
            current_time <= target;
          end
        end
        ST_FIRE: begin
          if (go) begin
            pend_v    <= 1'b1;
            pend_kind <= RES_FIRE;
            pend_idx  <= pick;
            pend_ok   <= 1'b0;
            pend_time <= best;
            fires     <= fires + 1'b1;
            cnt       <= '0;
            found     <= 1'b0;
            best      <= target;
          end
        end
        ST_EMIT: begin
          if (go) begin
            pend_v <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // arm datapath
  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      h_q      <= idx_in;
      ticks_q  <= s_axis_tdata[IN_T_LO +: TICKS_W];
      reload_q <= s_axis_tdata[IN_RL_BIT];
    end
    if (ram_re) begin
      rd_valid_q <= entry_valid[ram_raddr];
    end
    if (state == ST_ARM_MUL) begin
      prod_q <= DIVD_W'(ticks_q) * DIVD_W'(US_PER_S);
      freq_q <= rd_valid_q ? rdata.frequency : '0;
    end
    if (state == ST_ARM_START && freq_q == '0) begin
      p_q <= PERIOD_MAX;
    end
    if (state == ST_ARM_WAIT && div_done) begin
      p_q <= PERIOD_W'(div_q);
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (push) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      m_axis_tdata <= {2'b00, pend_time, pend_ok, OUT_IDX_W'(pend_idx)};
      m_axis_tuser <= pend_kind;
      m_axis_tlast <= push_last;
    end
  end

  `include "multi_channel_alarm_timer_core_assert.svh"

  `MCAT_CHECK(a_fire_limit, fires <= FIRE_CNT_W'(MAX_FIRES))
  `MCAT_CHECK(a_armed_written, (armed & ~entry_valid) == '0)
  `MCAT_IMPLY(a_div_in_wait, div_done, state == ST_ARM_WAIT)
  `MCAT_IMPLY(a_fire_no_ok, m_axis_tvalid && m_axis_tuser == RES_FIRE, !m_axis_tdata[OUT_OK_BIT])

endmodule

/* dv/tb.sv */
// self-checking testbench of the alarm timer core
`timescale 1ns / 1ps
module tb
  import mcat_pkg::*;
();

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  handle;
    logic [31:0] freq;
    logic [31:0] ticks;
    logic        reload;
    logic        en;
  } cmd_t;

  typedef struct packed {
    logic        rkind;
    logic [4:0]  idx;
    logic        ok;
    logic [63:0] t;
    logic        last;
  } res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic [2:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic m_axis_tuser;
  logic m_axis_tlast;

  multi_channel_alarm_timer_core dut (.*);

  always #4 clk = ~clk;

  // timer bank model state
  logic [63:0] now_us;
  logic        t_act [TIMER_COUNT];
  logic        t_en [TIMER_COUNT];
  logic        t_rl [TIMER_COUNT];
  logic [31:0] t_freq [TIMER_COUNT];
  logic [51:0] t_per [TIMER_COUNT];
  logic [63:0] t_due [TIMER_COUNT];

  cmd_t cmd_q[$];
  res_t expected_words[$];
  int   mismatches = 0;
  bit   quiet = 1'b0;
  int   tx_gap = 0;
  int   rx_gap = 0;

  task automatic wipe_timer(input int i);
    t_act[i] = '0; t_en[i] = '0; t_rl[i] = '0;
    t_freq[i] = '0; t_per[i] = '0; t_due[i] = '0;
  endtask

  function automatic res_t mk(input logic rk, input int ix, input logic ok,
                              input logic [63:0] t, input logic last);
    res_t r;
    r.rkind = rk; r.idx = ix[4:0]; r.ok = ok; r.t = t; r.last = last;
    return r;
  endfunction

  // advance the model by one command and queue its words
  task automatic predict_bank(input cmd_t c);
    logic valid;
    int h;
    int pick;
    int n;
    logic [63:0] best;
    logic [63:0] target;
    logic [83:0] prod;
    logic [83:0] p;
    valid = c.handle < TIMER_COUNT;
    h = valid ? int'(c.handle) : 0;
    case (c.kind)
      KIND_ALLOC: begin
        pick = -1;
        for (int i = 0; i < TIMER_COUNT; i++)
          if (pick < 0 && !t_act[i]) pick = i;
        if (pick >= 0) begin
          wipe_timer(pick);
          t_act[pick] = 1'b1;
          t_freq[pick] = (c.freq != 0) ? c.freq : DEFAULT_FREQ;
          expected_words.push_back(mk(RES_ALLOC, pick, 1'b1, 64'd0, 1'b1));
        end else begin
          expected_words.push_back(mk(RES_ALLOC, 0, 1'b0, 64'd0, 1'b1));
        end
      end
      KIND_SET_EN: if (valid) t_en[h] = c.en;
      KIND_ARM: if (valid) begin
        if (t_freq[h] == 0) p = {32'd0, PERIOD_MAX};
        else begin
          prod = 84'(c.ticks) * 84'd1000000;
          p = prod / 84'(t_freq[h]);
        end
        p = p & {32'd0, {52{1'b1}}};
        if (p == 0) p = 84'd1;
        t_per[h] = p[51:0];
        t_rl[h] = c.reload;
        t_due[h] = now_us + 64'(p[51:0]);
      end
      KIND_REMOVE: if (valid) wipe_timer(h);
      KIND_CLEAR: for (int i = 0; i < TIMER_COUNT; i++) wipe_timer(i);
      KIND_TICK: begin
        target = now_us + 64'd1;
        n = 0;
        while (n < MAX_FIRES) begin
          pick = -1;
          best = target;
          for (int i = 0; i < TIMER_COUNT; i++)
            if (t_act[i] && t_en[i] && t_per[i] != 0 && t_due[i] <= best) begin
              pick = i;
              best = t_due[i];
            end
          if (pick < 0) break;
          if (t_rl[pick]) t_due[pick] = best + 64'(t_per[pick]);
          else t_per[pick] = '0;
          expected_words.push_back(mk(RES_FIRE, pick, 1'b0, best, 1'b0));
          n++;
        end
        now_us = target;
        if (n > 0) expected_words[$].last = 1'b1;
      end
      default: ;
    endcase
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (tx_gap > 0) begin
        tx_gap <= tx_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (cmd_q.size() > 0) begin
        cmd_t c;
        c = cmd_q.pop_front();
        predict_bank(c);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= c.kind;
        s_axis_tdata <= {6'd0, c.en, c.reload, c.ticks, c.freq, c.handle};
        if (!quiet && $urandom_range(0, 9) == 0) tx_gap <= $urandom_range(1, 12);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // monitor and output stall
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        res_t got;
        res_t want;
        got = mk(m_axis_tuser, int'(m_axis_tdata[4:0]), m_axis_tdata[OUT_OK_BIT],
                 m_axis_tdata[OUT_T_LO +: 64], m_axis_tlast);
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word %h", got);
        end else begin
          want = expected_words.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: expected kind %0d idx %0d ok %0d t %0d last %0d,",
                        " got kind %0d idx %0d ok %0d t %0d last %0d"},
                       want.rkind, want.idx, want.ok, want.t, want.last,
                       got.rkind, got.idx, got.ok, got.t, got.last);
          end
        end
      end
      if (rx_gap > 0) begin
        rx_gap <= rx_gap - 1;
        m_axis_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        rx_gap <= $urandom_range(1, 12);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  function automatic cmd_t mkc(input logic [2:0] k, input logic [7:0] h,
                               input logic [31:0] f, input logic [31:0] tk,
                               input logic rl, input logic en);
    cmd_t c;
    c.kind = k; c.handle = h; c.freq = f; c.ticks = tk; c.reload = rl; c.en = en;
    return c;
  endfunction

  function automatic cmd_t rand_cmd();
    cmd_t c;
    int r;
    c = mkc(3'($urandom_range(0, 7)), 8'($urandom), $urandom, $urandom,
            1'($urandom), 1'($urandom));
    r = $urandom_range(0, 99);
    // mostly well-formed traffic: valid handles, short alarms, many ticks
    if (r < 45) c.kind = KIND_TICK;
    else if (r < 55) c.kind = KIND_ALLOC;
    else if (r < 68) c.kind = KIND_SET_EN;
    else if (r < 85) c.kind = KIND_ARM;
    else if (r < 92) c.kind = KIND_REMOVE;
    else if (r < 94) c.kind = KIND_CLEAR;
    if ($urandom_range(0, 9) != 0) c.handle = 8'($urandom_range(0, TIMER_COUNT - 1));
    if ($urandom_range(0, 4) != 0) c.freq = $urandom_range(1000, 2000000);
    if ($urandom_range(0, 5) != 0) c.ticks = $urandom_range(0, 40);
    if ($urandom_range(0, 3) != 0) c.en = 1'b1;
    return c;
  endfunction

  task automatic wait_drained();
    while (cmd_q.size() > 0 || s_axis_tvalid || expected_words.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    now_us = '0;
    for (int i = 0; i < TIMER_COUNT; i++) wipe_timer(i);
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    // directed: fill bank, overflow, zero freq, extremes, out of range handles
    cmd_q.push_back(mkc(KIND_ARM, 8'd7, 32'd0, 32'd5, 1'b0, 1'b0));
    cmd_q.push_back(mkc(KIND_ALLOC, 8'd0, 32'd0, 32'd0, 1'b0, 1'b0));
    cmd_q.push_back(mkc(KIND_ALLOC, 8'd0, 32'hFFFFFFFF, 32'd0, 1'b0, 1'b0));
    for (int i = 0; i < TIMER_COUNT - 2; i++)
      cmd_q.push_back(mkc(KIND_ALLOC, 8'd0, 32'd1000000, 32'd0, 1'b0, 1'b0));
    cmd_q.push_back(mkc(KIND_ALLOC, 8'hFF, 32'd1, 32'hFFFFFFFF, 1'b1, 1'b1));
    cmd_q.push_back(mkc(KIND_ARM, 8'd0, 32'd0, 32'd2, 1'b1, 1'b0));
    cmd_q.push_back(mkc(KIND_ARM, 8'd1, 32'd0, 32'd0, 1'b1, 1'b0));
    cmd_q.push_back(mkc(KIND_ARM, 8'd2, 32'd0, 32'hFFFFFFFF, 1'b0, 1'b0));
    cmd_q.push_back(mkc(KIND_ARM, 8'd3, 32'd0, 32'd1, 1'b0, 1'b0));
    cmd_q.push_back(mkc(KIND_SET_EN, 8'd0, 32'd0, 32'd0, 1'b0, 1'b1));
    cmd_q.push_back(mkc(KIND_SET_EN, 8'd1, 32'd0, 32'd0, 1'b0, 1'b1));
    cmd_q.push_back(mkc(KIND_SET_EN, 8'd3, 32'd0, 32'd0, 1'b0, 1'b1));
    cmd_q.push_back(mkc(KIND_SET_EN, 8'd8, 32'd0, 32'd0, 1'b0, 1'b1));
    for (int i = 0; i < 3; i++)
      cmd_q.push_back(mkc(KIND_TICK, 8'd0, 32'd0, 32'd0, 1'b0, 1'b0));
    cmd_q.push_back(mkc(KIND_REMOVE, 8'd1, 32'd0, 32'd0, 1'b0, 1'b0));
    cmd_q.push_back(mkc(KIND_REMOVE, 8'd200, 32'd0, 32'd0, 1'b0, 1'b0));
    cmd_q.push_back(mkc(3'd6, 8'd0, 32'd0, 32'd0, 1'b0, 1'b0));
    cmd_q.push_back(mkc(3'd7, 8'd0, 32'd0, 32'd0, 1'b0, 1'b0));
    cmd_q.push_back(mkc(KIND_TICK, 8'd0, 32'd0, 32'd0, 1'b0, 1'b0));
    cmd_q.push_back(mkc(KIND_CLEAR, 8'd0, 32'd0, 32'd0, 1'b0, 1'b0));
    // fire limit: eight period-one reload timers, more than a tick's worth of backlog
    for (int i = 0; i < TIMER_COUNT; i++) begin
      cmd_q.push_back(mkc(KIND_ALLOC, 8'd0, 32'd0, 32'd0, 1'b0, 1'b0));
      cmd_q.push_back(mkc(KIND_ARM, 8'(i), 32'd0, 32'd0, 1'b1, 1'b0));
    end
    for (int i = 0; i < 12; i++)
      cmd_q.push_back(mkc(KIND_TICK, 8'd0, 32'd0, 32'd0, 1'b0, 1'b0));
    for (int i = 0; i < TIMER_COUNT; i++)
      cmd_q.push_back(mkc(KIND_SET_EN, 8'(i), 32'd0, 32'd0, 1'b0, 1'b1));
    for (int i = 0; i < 3; i++)
      cmd_q.push_back(mkc(KIND_TICK, 8'd0, 32'd0, 32'd0, 1'b0, 1'b0));
    cmd_q.push_back(mkc(KIND_CLEAR, 8'd0, 32'd0, 32'd0, 1'b0, 1'b0));
    // random traffic
    for (int i = 0; i < 145; i++) begin
      if (i == 115) begin
        wait_drained();
        quiet = 1'b1;
      end
      cmd_q.push_back(rand_cmd());
    end
    wait_drained();
    repeat (2000) @(posedge clk);
    if (mismatches == 0 && expected_words.size() == 0)
      $display("multi_channel_alarm_timer_core regression: pass");
    else
      $display("multi_channel_alarm_timer_core regression: fail");
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("multi_channel_alarm_timer_core regression: fail");
    $finish;
  end

endmodule
